// ----- rtl/sap_pkg.sv -----
`default_nettype none
package sap_pkg;

   // stored coordinate and width; covers any clamped atlas side
   localparam int COORD_W    = 13;
   // skyline height: zero-width items can stack above the atlas top
   localparam int SKY_Y_W    = COORD_W + 1;
   localparam int OUT_W      = 12;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   localparam logic [STATUS_W-1:0] ST_PLACED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_FIT = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ATLAS_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ATLAS_HEIGHT = 2'd1;

   typedef struct packed {
      logic [COORD_W-1:0] req_width;
      logic [COORD_W-1:0] req_height;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0]    place_x;
      logic [OUT_W-1:0]    place_y;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [SKY_Y_W-1:0] y;
      logic [COORD_W-1:0] wd;
   } seg_type;

endpackage
`default_nettype wire

// ----- rtl/skyline_atlas_packer.sv -----
`default_nettype none
// Channel  Dir  Handshake              Payload
// req_     in   req_valid/req_ready    req_data  (req_width, req_height)
// rsp_     out  rsp_valid/rsp_ready    rsp_data  (place_x, place_y, status)
// csr_     in   csr_we                 csr_index, csr_wdata
//
// One item at a time. Each start segment is read and then tested; a walk reads and
// tests each further segment it spans, or stops when it runs off the right end;
// then come the rebuild and the post step. A no-fit skips the rebuild, a full-list
// refusal goes straight to post. Every step reads one entry of the segment memory
// (one registered read port), which is why each entry takes a read and a test state.
// Synchronous reset reloads the registers and writes the one-segment skyline
// in the same cycle; no clearing pass. The result sits in an output register,
// so a stalled rsp_ only holds the block once the next result is ready.
module skyline_atlas_packer #(
   parameter int MAX_SEGMENTS = 64,
   parameter int MAX_SIDE     = 4096
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire sap_pkg::req_type        req_data,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output sap_pkg::rsp_type             rsp_data,
   input  wire                          csr_we,
   input  wire [sap_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire [sap_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import sap_pkg::*;

   localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
   localparam int IDX_W  = $clog2(MAX_SEGMENTS);
   localparam int ADDR_W = IDX_W + 1;           // bank bit + index
   localparam int SUM_W  = COORD_W + 1;
   localparam int TOP_W  = SKY_Y_W + 1;         // height plus rectangle height
   localparam int LEFT_W = COORD_W + 2;
   localparam int COORD_MAX  = (1 << COORD_W) - 1;
   localparam int MAX_SIDE_C = (MAX_SIDE > COORD_MAX) ? COORD_MAX : MAX_SIDE;
   localparam int RESET_SIDE = (512 > MAX_SIDE_C) ? MAX_SIDE_C : 512;

   // sequencer states
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_FIT_RD  = 3'd1;  // read start segment
   localparam logic [2:0] S_FIT_CHK = 3'd2;  // test start segment
   localparam logic [2:0] S_WALK_RD = 3'd3;  // read next spanned segment
   localparam logic [2:0] S_WALK_CHK= 3'd4;
   localparam logic [2:0] S_RB_CHK  = 3'd5;  // rebuild: insert / read / flush
   localparam logic [2:0] S_RB_DATA = 3'd6;  // rebuild: trim and merge
   localparam logic [2:0] S_POST    = 3'd7;  // hand result to output register

   function automatic logic [COORD_W-1:0] clamp_side(input logic [CSR_DATA_W-1:0] v);
      if (v < CSR_DATA_W'(3))
         return COORD_W'(3);
      else if (32'(v) > MAX_SIDE_C)
         return COORD_W'(MAX_SIDE_C);
      else
         return COORD_W'(v);
   endfunction

   // segment memory, two banks: fit reads the live bank, rebuild writes the other
   seg_type mem [0:(1 << ADDR_W)-1];
   seg_type rd_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_wa;
   seg_type           mem_wd;

   logic [2:0]         state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               bank_ff, bank_in;
   logic [COORD_W-1:0] aw_ff, aw_in, ah_ff, ah_in;
   logic [COORD_W-1:0] w_ff, w_in, h_ff, h_in;
   logic [CNT_W-1:0]   i_ff, i_in, j_ff, j_in, r_ff, r_in, wc_ff, wc_in;
   logic [CNT_W-1:0]   best_ff, best_in;
   logic               found_ff, found_in;
   logic [TOP_W-1:0]   best_top_ff, best_top_in;
   logic [COORD_W-1:0] best_w_ff, best_w_in;
   logic [COORD_W-1:0] px_ff, px_in;
   logic [SKY_Y_W-1:0] py_ff, py_in;
   logic [COORD_W-1:0] cur_x_ff, cur_x_in, cur_w_ff, cur_w_in;
   logic [SKY_Y_W-1:0] ymax_ff, ymax_in;
   logic signed [LEFT_W-1:0] left_ff, left_in;
   logic               ins_ff, ins_in, trim_ff, trim_in;
   logic [COORD_W-1:0] end_ff, end_in;
   seg_type            pend_ff, pend_in;
   logic               pv_ff, pv_in;
   rsp_type            res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   // per-cycle helpers
   logic               push_en;
   seg_type            push_seg;
   logic               cand_en;
   logic [SKY_Y_W-1:0] cand_rest;
   logic [COORD_W-1:0] cand_wd, cand_x;
   logic [TOP_W-1:0]   cand_top;
   logic               adv;
   logic [SKY_Y_W-1:0] ymax_n;
   logic signed [LEFT_W-1:0] left_n;
   logic [SUM_W-1:0]   seg_end;
   logic [COORD_W-1:0] csr_side;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_side  = clamp_side(csr_wdata);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      bank_in     = bank_ff;
      aw_in       = aw_ff;
      ah_in       = ah_ff;
      w_in        = w_ff;
      h_in        = h_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      r_in        = r_ff;
      wc_in       = wc_ff;
      best_in     = best_ff;
      found_in    = found_ff;
      best_top_in = best_top_ff;
      best_w_in   = best_w_ff;
      px_in       = px_ff;
      py_in       = py_ff;
      cur_x_in    = cur_x_ff;
      cur_w_in    = cur_w_ff;
      ymax_in     = ymax_ff;
      left_in     = left_ff;
      ins_in      = ins_ff;
      trim_in     = trim_ff;
      end_in      = end_ff;
      pend_in     = pend_ff;
      pv_in       = pv_ff;
      res_in      = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      push_en   = 1'b0;
      push_seg  = rd_ff;
      cand_en   = 1'b0;
      cand_rest = rd_ff.y;
      cand_wd   = rd_ff.wd;
      cand_x    = rd_ff.x;
      cand_top  = '0;
      adv       = 1'b0;
      ymax_n    = rd_ff.y;
      left_n    = '0;
      seg_end   = '0;

      rd_addr = {bank_ff, i_ff[IDX_W-1:0]};
      mem_we  = 1'b0;
      mem_wa  = {~bank_ff, wc_ff[IDX_W-1:0]};
      mem_wd  = pend_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               w_in = req_data.req_width;
               h_in = req_data.req_height;
               if (count_ff == CNT_W'(MAX_SEGMENTS)) begin
                  res_in   = '{place_x: '0, place_y: '0, status: ST_FULL};
                  state_in = S_POST;
               end else begin
                  i_in     = '0;
                  found_in = 1'b0;
                  state_in = S_FIT_RD;
               end
            end
         end
         S_FIT_RD: begin
            rd_addr  = {bank_ff, i_ff[IDX_W-1:0]};
            state_in = S_FIT_CHK;
         end
         S_FIT_CHK: begin
            cur_x_in = rd_ff.x;
            cur_w_in = rd_ff.wd;
            ymax_in  = rd_ff.y;
            left_n   = $signed({2'b00, w_ff}) - $signed({2'b00, rd_ff.wd});
            left_in  = left_n;
            j_in     = i_ff + CNT_W'(1);
            if (({1'b0, rd_ff.x} + {1'b0, w_ff}) > ({1'b0, aw_ff} - SUM_W'(1))) begin
               adv = 1'b1;
            end else if (w_ff == '0) begin
               cand_en = 1'b1;            // zero width: no height check
               adv     = 1'b1;
            end else if ((TOP_W'(rd_ff.y) + TOP_W'(h_ff)) >
                         TOP_W'(ah_ff - COORD_W'(1))) begin
               adv = 1'b1;
            end else if (left_n <= 0) begin
               cand_en = 1'b1;
               adv     = 1'b1;
            end else begin
               state_in = S_WALK_RD;
            end
         end
         S_WALK_RD: begin
            rd_addr = {bank_ff, j_ff[IDX_W-1:0]};
            if (j_ff >= count_ff)
               adv = 1'b1;                // ran off the right end
            else
               state_in = S_WALK_CHK;
         end
         S_WALK_CHK: begin
            ymax_n  = (rd_ff.y > ymax_ff) ? rd_ff.y : ymax_ff;
            left_n  = left_ff - $signed({2'b00, rd_ff.wd});
            ymax_in = ymax_n;
            left_in = left_n;
            j_in    = j_ff + CNT_W'(1);
            if ((TOP_W'(ymax_n) + TOP_W'(h_ff)) > TOP_W'(ah_ff - COORD_W'(1))) begin
               adv = 1'b1;
            end else if (left_n <= 0) begin
               cand_en   = 1'b1;
               cand_rest = ymax_n;
               cand_wd   = cur_w_ff;
               cand_x    = cur_x_ff;
               adv       = 1'b1;
            end else begin
               state_in = S_WALK_RD;
            end
         end
         S_RB_CHK: begin
            rd_addr = {bank_ff, r_ff[IDX_W-1:0]};
            if (!ins_ff && r_ff == best_ff) begin
               // new top segment goes in ahead of the chosen start
               push_en  = 1'b1;
               push_seg = '{x: px_ff, y: py_ff + SKY_Y_W'(h_ff), wd: w_ff};
               ins_in   = 1'b1;
               end_in   = COORD_W'(px_ff + w_ff);
            end else if (r_ff < count_ff) begin
               state_in = S_RB_DATA;
            end else begin
               // flush last pending segment, swap banks
               mem_we   = 1'b1;
               mem_wa   = {~bank_ff, wc_ff[IDX_W-1:0]};
               mem_wd   = pend_ff;
               count_in = wc_ff + CNT_W'(1);
               bank_in  = ~bank_ff;
               res_in   = '{place_x: px_ff[OUT_W-1:0], place_y: py_ff[OUT_W-1:0],
                            status: ST_PLACED};
               state_in = S_POST;
            end
         end
         S_RB_DATA: begin
            seg_end = {1'b0, rd_ff.x} + {1'b0, rd_ff.wd};
            r_in    = r_ff + CNT_W'(1);
            state_in = S_RB_CHK;
            if (ins_ff && trim_ff) begin
               if (rd_ff.x >= end_ff) begin
                  push_en = 1'b1;
                  trim_in = 1'b0;
               end else if (seg_end > {1'b0, end_ff}) begin
                  push_en  = 1'b1;
                  push_seg = '{x: end_ff, y: rd_ff.y,
                               wd: COORD_W'(seg_end - {1'b0, end_ff})};
                  trim_in  = 1'b0;
               end
               // else fully covered: dropped
            end else begin
               push_en = 1'b1;
            end
         end
         S_POST: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // candidate compare: lowest top, then narrowest start
      if (cand_en) begin
         cand_top = TOP_W'(cand_rest) + TOP_W'(h_ff);
         if (!found_ff || cand_top < best_top_ff ||
             (cand_top == best_top_ff && cand_wd < best_w_ff)) begin
            found_in    = 1'b1;
            best_in     = i_ff;
            best_top_in = cand_top;
            best_w_in   = cand_wd;
            px_in       = cand_x;
            py_in       = cand_rest;
         end
      end

      // next start segment, or decide
      if (adv) begin
         i_in = i_ff + CNT_W'(1);
         if (i_in == count_ff) begin
            if (found_in) begin
               r_in     = '0;
               wc_in    = '0;
               pv_in    = 1'b0;
               ins_in   = 1'b0;
               trim_in  = 1'b1;
               state_in = S_RB_CHK;
            end else begin
               res_in   = '{place_x: '0, place_y: '0, status: ST_NO_FIT};
               state_in = S_POST;
            end
         end else begin
            state_in = S_FIT_RD;
         end
      end

      // merge equal heights on the way into the other bank
      if (push_en) begin
         if (!pv_ff) begin
            pend_in = push_seg;
            pv_in   = 1'b1;
         end else if (push_seg.y == pend_ff.y) begin
            pend_in.wd = pend_ff.wd + push_seg.wd;
         end else begin
            mem_we  = 1'b1;
            mem_wa  = {~bank_ff, wc_ff[IDX_W-1:0]};
            mem_wd  = pend_ff;
            wc_in   = wc_ff + CNT_W'(1);
            pend_in = push_seg;
         end
      end

      // register write: new side, skyline back to one segment
      if (csr_we && (csr_index == CSR_ATLAS_WIDTH || csr_index == CSR_ATLAS_HEIGHT)) begin
         if (csr_index == CSR_ATLAS_WIDTH)
            aw_in = csr_side;
         else
            ah_in = csr_side;
         count_in = CNT_W'(1);
         mem_we   = 1'b1;
         mem_wa   = {bank_ff, {IDX_W{1'b0}}};
         mem_wd   = '{x: COORD_W'(1), y: SKY_Y_W'(1), wd: aw_in - COORD_W'(2)};
      end

      if (reset) begin
         mem_we = 1'b1;
         mem_wa = '0;
         mem_wd = '{x: COORD_W'(1), y: SKY_Y_W'(1), wd: COORD_W'(RESET_SIDE - 2)};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we)
         mem[mem_wa] <= mem_wd;
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= CNT_W'(1);
         bank_ff      <= 1'b0;
         aw_ff        <= COORD_W'(RESET_SIDE);
         ah_ff        <= COORD_W'(RESET_SIDE);
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         pv_ff        <= 1'b0;
         ins_ff       <= 1'b0;
         trim_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         bank_ff      <= bank_in;
         aw_ff        <= aw_in;
         ah_ff        <= ah_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
         pv_ff        <= pv_in;
         ins_ff       <= ins_in;
         trim_ff      <= trim_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff        <= w_in;
      h_ff        <= h_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      r_ff        <= r_in;
      wc_ff       <= wc_in;
      best_ff     <= best_in;
      best_top_ff <= best_top_in;
      best_w_ff   <= best_w_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      cur_x_ff    <= cur_x_in;
      cur_w_ff    <= cur_w_in;
      ymax_ff     <= ymax_in;
      left_ff     <= left_in;
      end_ff      <= end_in;
      pend_ff     <= pend_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
`default_nettype wire
